### hdl/pfs_pkg.sv
// Shared types and constants of the packet flow sampler.
package pfs_pkg;

    localparam int MAX_INTERFACES = 64;
    localparam int IF_W           = $clog2(MAX_INTERFACES);
    localparam int SLOTS          = MAX_INTERFACES * 6;
    localparam int SLOT_W         = $clog2(SLOTS);

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [5:0]  POS_MAX   = 6'd63;
    localparam logic [5:0]  MIN_FRAME = 6'd14;
    localparam logic [5:0]  HDR_V4    = 6'd34;
    localparam logic [5:0]  HDR_V6    = 6'd54;
    localparam logic [5:0]  L4_BYTES  = 6'd4;

    localparam logic [1:0]  CLS_OTHER = 2'd0;
    localparam logic [1:0]  CLS_V4    = 2'd1;
    localparam logic [1:0]  CLS_V6    = 2'd2;

    localparam logic        REG_SAMPLE_RATE = 1'b0;

    typedef enum logic [2:0] {
        K_PKT    = 3'd0,
        K_BYTE   = 3'd1,
        K_META   = 3'd2,
        K_SRC_HI = 3'd3,
        K_SRC_LO = 3'd4,
        K_DST_HI = 3'd5,
        K_DST_LO = 3'd6,
        K_DROP   = 3'd7
    } t_kind;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [5:0]  interface_index;
        logic        direction;
        logic [15:0] packet_length;
        logic [31:0] random_word;
        logic        sink_full;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [63:0] record_word;
        logic        last_of_run;
    } t_out_word;

    typedef struct packed {
        logic  clr;
        logic  take;
        logic  upd;
        logic  div_init;
        logic  div_step;
        logic  load;
        t_kind kind;
        logic  last;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_last;
        logic frame_ok;
        logic need_div;
        logic div_last;
        logic sampled;
        logic sink_full;
        logic out_free;
    } t_dp_stat;

endpackage

### hdl/pfs_ctrl.sv
// Sequencer: counter clear, byte intake, counter update, modulo, record emission.
module pfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pfs_pkg::t_dp_stat i_stat,
    output pfs_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_WRITE = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    pfs_pkg::t_kind r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
                if (i_valid && i_stat.in_last && i_stat.frame_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.upd      = 1'b1;
                o_cmd.div_init = 1'b1;
                n_kind         = pfs_pkg::K_PKT;
                n_state        = i_stat.need_div ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    case (r_kind)
                        pfs_pkg::K_PKT:    n_kind = pfs_pkg::K_BYTE;
                        pfs_pkg::K_BYTE: begin
                            o_cmd.last = !i_stat.sampled;
                            n_kind = i_stat.sink_full ? pfs_pkg::K_DROP : pfs_pkg::K_META;
                        end
                        pfs_pkg::K_META:   n_kind = pfs_pkg::K_SRC_HI;
                        pfs_pkg::K_SRC_HI: n_kind = pfs_pkg::K_SRC_LO;
                        pfs_pkg::K_SRC_LO: n_kind = pfs_pkg::K_DST_HI;
                        pfs_pkg::K_DST_HI: n_kind = pfs_pkg::K_DST_LO;
                        pfs_pkg::K_DST_LO: o_cmd.last = 1'b1;
                        pfs_pkg::K_DROP:   o_cmd.last = 1'b1;
                        default:           o_cmd.last = 1'b1;
                    endcase
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= pfs_pkg::K_PKT;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

### hdl/pfs_dpath.sv
// Datapath: header parse, counter memories, modulo unit, drop counter, output register.
module pfs_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfs_pkg::t_in_word i_data,
    input  logic [31:0]       i_rate,
    input  pfs_pkg::t_ctl_cmd i_cmd,
    output pfs_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output pfs_pkg::t_out_word o_data
);

    // parse state
    logic [5:0]   r_pos;
    logic [15:0]  r_et, n_et;
    logic [7:0]   r_proto, n_proto;
    logic [127:0] r_src, n_src;
    logic [127:0] r_dst, n_dst;
    logic [31:0]  r_port, n_port;
    logic [5:0]   pos, n_pos_inc;
    logic [3:0]   src_idx, dst_idx;
    logic         src_hit, dst_hit, port_hit;
    logic [1:0]   port_idx;

    // frame metadata
    logic [5:0]  r_ifc;
    logic        r_dir;
    logic [15:0] r_len;
    logic [31:0] r_rnd;
    logic        r_sink_full;
    logic [5:0]  r_count;

    // counters
    logic [63:0] mem_pkt  [pfs_pkg::SLOTS];
    logic [63:0] mem_byte [pfs_pkg::SLOTS];
    logic [63:0] r_pkt_rd, r_byte_rd, r_pkt_new, r_byte_new;
    logic [pfs_pkg::SLOT_W-1:0] r_clr_addr, slot, wr_addr;
    logic        wr_en;
    logic [63:0] wr_pkt, wr_byte;
    logic [63:0] r_drop;

    // modulo unit
    logic [31:0] r_rem, r_dvd;
    logic [4:0]  r_dcnt;
    logic [32:0] trial;

    logic [1:0]  cls;
    logic [5:0]  need_hdr;
    logic        ports;
    logic [63:0] src_hi, src_lo, dst_hi, dst_lo, meta, word;
    logic        r_ovalid;
    pfs_pkg::t_out_word r_out;

    always_comb begin
        pos      = i_data.first_byte ? 6'd0 : r_pos;
        n_et     = i_data.first_byte ? 16'd0 : r_et;
        n_proto  = i_data.first_byte ? 8'd0 : r_proto;
        n_src    = i_data.first_byte ? 128'd0 : r_src;
        n_dst    = i_data.first_byte ? 128'd0 : r_dst;
        n_port   = i_data.first_byte ? 32'd0 : r_port;
        n_pos_inc = (pos < pfs_pkg::POS_MAX) ? pos + 6'd1 : pfs_pkg::POS_MAX;
        src_hit  = 1'b0;
        dst_hit  = 1'b0;
        port_hit = 1'b0;
        src_idx  = '0;
        dst_idx  = '0;
        port_idx = '0;
        if (pos == 6'd12) begin
            n_et[15:8] = i_data.data_byte;
        end else if (pos == 6'd13) begin
            n_et[7:0] = i_data.data_byte;
        end else if (n_et == pfs_pkg::ETH_IPV4) begin
            if (pos == 6'd23) n_proto = i_data.data_byte;
            src_hit  = (pos >= 6'd26) && (pos < 6'd30);
            dst_hit  = (pos >= 6'd30) && (pos < 6'd34);
            port_hit = (pos >= 6'd34) && (pos < 6'd38);
            src_idx  = 4'(pos - 6'd14);
            dst_idx  = 4'(pos - 6'd18);
            port_idx = 2'(pos - 6'd34);
        end else if (n_et == pfs_pkg::ETH_IPV6) begin
            if (pos == 6'd20) n_proto = i_data.data_byte;
            src_hit  = (pos >= 6'd22) && (pos < 6'd38);
            dst_hit  = (pos >= 6'd38) && (pos < 6'd54);
            port_hit = (pos >= 6'd54) && (pos < 6'd58);
            src_idx  = 4'(pos - 6'd22);
            dst_idx  = 4'(pos - 6'd38);
            port_idx = 2'(pos - 6'd54);
        end
        for (int i = 0; i < 16; i++) begin
            if (src_hit && src_idx == 4'(i)) n_src[127-8*i -: 8] = i_data.data_byte;
            if (dst_hit && dst_idx == 4'(i)) n_dst[127-8*i -: 8] = i_data.data_byte;
        end
        for (int j = 0; j < 4; j++) begin
            if (port_hit && port_idx == 2'(j)) n_port[31-8*j -: 8] = i_data.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_et    <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_port  <= '0;
            r_ifc   <= '0;
            r_dir   <= 1'b0;
            r_len   <= '0;
            r_rnd   <= '0;
        end else if (i_cmd.take) begin
            r_pos   <= i_data.last_byte ? 6'd0 : n_pos_inc;
            r_et    <= n_et;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_port  <= n_port;
            if (i_data.first_byte) begin
                r_ifc <= i_data.interface_index;
                r_dir <= i_data.direction;
                r_len <= i_data.packet_length;
                r_rnd <= i_data.random_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_data.last_byte) begin
            r_count     <= n_pos_inc;
            r_sink_full <= i_data.sink_full;
        end
    end

    // counter slot
    always_comb begin
        cls = (r_et == pfs_pkg::ETH_IPV4) ? pfs_pkg::CLS_V4 :
              (r_et == pfs_pkg::ETH_IPV6) ? pfs_pkg::CLS_V6 : pfs_pkg::CLS_OTHER;
        slot = pfs_pkg::SLOT_W'({r_ifc[pfs_pkg::IF_W-1:0], r_dir}) * pfs_pkg::SLOT_W'(3)
             + pfs_pkg::SLOT_W'(cls);
        wr_en   = i_cmd.clr || i_cmd.upd;
        wr_addr = i_cmd.clr ? r_clr_addr : slot;
        wr_pkt  = i_cmd.clr ? 64'd0 : r_pkt_rd + 64'd1;
        wr_byte = i_cmd.clr ? 64'd0 : r_byte_rd + 64'(r_len);
    end

    always_ff @(posedge i_clk) begin
        r_pkt_rd  <= mem_pkt[slot];
        r_byte_rd <= mem_byte[slot];
        if (wr_en) begin
            mem_pkt[wr_addr]  <= wr_pkt;
            mem_byte[wr_addr] <= wr_byte;
        end
        if (i_cmd.upd) begin
            r_pkt_new  <= wr_pkt;
            r_byte_new <= wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + pfs_pkg::SLOT_W'(1);
        end
    end

    // restoring remainder, one dividend bit per cycle
    assign trial = {r_rem, r_dvd[31]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_dvd  <= r_rnd;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= (trial >= {1'b0, i_rate}) ? 32'(trial - {1'b0, i_rate}) : trial[31:0];
            r_dvd  <= {r_dvd[30:0], 1'b0};
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    // record contents
    always_comb begin
        need_hdr = (cls == pfs_pkg::CLS_V4) ? pfs_pkg::HDR_V4 : pfs_pkg::HDR_V6;
        ports    = (r_proto == pfs_pkg::PROTO_TCP) || (r_proto == pfs_pkg::PROTO_UDP);
        if (cls == pfs_pkg::CLS_V4) begin
            src_hi = '0;
            dst_hi = '0;
            src_lo = {32'h0000_ffff, r_src[31:0]};
            dst_lo = {32'h0000_ffff, r_dst[31:0]};
        end else begin
            src_hi = r_src[127:64];
            dst_hi = r_dst[127:64];
            src_lo = r_src[63:0];
            dst_lo = r_dst[63:0];
        end
        meta = {1'b0, r_ifc, r_dir, r_proto, r_len, ports ? r_port : 32'd0};
        case (i_cmd.kind)
            pfs_pkg::K_PKT:    word = r_pkt_new;
            pfs_pkg::K_BYTE:   word = r_byte_new;
            pfs_pkg::K_META:   word = meta;
            pfs_pkg::K_SRC_HI: word = src_hi;
            pfs_pkg::K_SRC_LO: word = src_lo;
            pfs_pkg::K_DST_HI: word = dst_hi;
            pfs_pkg::K_DST_LO: word = dst_lo;
            pfs_pkg::K_DROP:   word = r_drop + 64'd1;
            default:           word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.load && i_cmd.kind == pfs_pkg::K_DROP) begin
                r_drop <= word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.record_kind <= i_cmd.kind;
            r_out.record_word <= word;
            r_out.last_of_run <= i_cmd.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign o_stat.clr_done  = (r_clr_addr == pfs_pkg::SLOT_W'(pfs_pkg::SLOTS - 1));
    assign o_stat.in_last   = i_data.last_byte;
    assign o_stat.frame_ok  = (n_pos_inc >= pfs_pkg::MIN_FRAME);
    assign o_stat.need_div  = (cls != pfs_pkg::CLS_OTHER) && (i_rate != 32'd0);
    assign o_stat.div_last  = (r_dcnt == 5'd31);
    assign o_stat.sampled   = o_stat.need_div && (r_rem == 32'd0) && (r_count >= need_hdr)
                              && !(ports && (r_count < need_hdr + pfs_pkg::L4_BYTES));
    assign o_stat.sink_full = r_sink_full;
    assign o_stat.out_free  = !r_ovalid || i_ready;

endmodule

### hdl/packet_flow_sampler_top.sv
// Top level of the packet flow sampler: APB register, sequencer and datapath.
//
// Frame bytes enter one word per cycle while a frame is being received. On the
// last byte of a frame of 14 bytes or more the block leaves intake and does the
// per-frame work: it reads the counter memories, writes back the
// updated packet and byte counts, then for an IP frame with a nonzero sample
// rate runs a bit-serial remainder unit (random word mod sample rate), then
// sends the result words (2, 3 or 7 words) one per cycle as the sink takes them.
// Intake is blocked during that work. After reset the counter memories are
// cleared, one slot a cycle, and no word is accepted while they are; APB writes
// are taken at any time.
module packet_flow_sampler_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pfs_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output pfs_pkg::t_out_word  o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    pfs_pkg::t_ctl_cmd cmd;
    pfs_pkg::t_dp_stat stat;
    logic [31:0]       r_rate;

    // sample rate register, zero turns sampling off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= '0;
        end else if (psel && penable && pwrite && paddr == {1'b0, pfs_pkg::REG_SAMPLE_RATE}) begin
            r_rate <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == {1'b0, pfs_pkg::REG_SAMPLE_RATE}) ? r_rate : 32'd0;

    pfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pfs_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_rate  (r_rate),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
